>>> sv/fgr_pkg.sv
`default_nettype none

package fgr_pkg;

   localparam int SIDE_DEFAULT = 256;

   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   localparam logic [CHAN_W-1:0] CHAN_WHITE = 8'hFF;

   typedef enum logic [3:0] {
      MODE_FLIP_H   = 4'd0,
      MODE_FLIP_V   = 4'd1,
      MODE_ROT90    = 4'd2,
      MODE_ROT180   = 4'd3,
      MODE_ROT270   = 4'd4,
      MODE_MIRROR_L = 4'd5,
      MODE_MIRROR_R = 4'd6,
      MODE_MIRROR_U = 4'd7,
      MODE_MIRROR_D = 4'd8,
      MODE_ZOOM     = 4'd9,
      MODE_SHUFFLE  = 4'd10,
      MODE_CROP     = 4'd11
   } fgr_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TRANSFORM_MODE   = 3'd0,
      REG_ZOOM_QUARTER     = 3'd1,
      REG_QUADRANT_SOURCES = 3'd2,
      REG_CROP_LEFT        = 3'd3,
      REG_CROP_TOP         = 3'd4,
      REG_CROP_HEIGHT      = 3'd5,
      REG_CROP_WIDTH       = 3'd6
   } fgr_reg_type;

   localparam logic [3:0] MODE_RESET  = 4'd15;
   localparam logic [1:0] ZOOM_RESET  = 2'd0;
   localparam logic [7:0] QSRC_RESET  = 8'd228;
   localparam logic [7:0] CROP_ORIGIN_RESET = 8'd0;
   localparam logic [7:0] CROP_SPAN_RESET   = 8'd255;

   typedef struct packed {
      logic [3:0] transform_mode;
      logic [1:0] zoom_quarter;
      logic [7:0] quadrant_sources;
      logic [7:0] crop_left;
      logic [7:0] crop_top;
      logic [7:0] crop_height;
      logic [7:0] crop_width;
   } fgr_cfg_type;

   // per-item control carried down the pipe
   typedef struct packed {
      logic rd;     // read, produces a result
      logic wr;     // store into the frame
      logic white;  // crop: outside window
      logic zero;   // read outside the frame
   } fgr_ctl_type;

endpackage

`default_nettype wire

>>> sv/fgr_remap.sv
`default_nettype none

module fgr_remap import fgr_pkg::*; #(
   parameter int SIDE = SIDE_DEFAULT,
   localparam int CW = $clog2(SIDE)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              kind,
   input  wire logic [7:0]        row,
   input  wire logic [7:0]        col,
   input  wire logic [PIX_W-1:0]  pix,
   input  wire fgr_cfg_type       cfg,
   output fgr_ctl_type            ctl_out,
   output logic [CW-1:0]          src_row_out,
   output logic [CW-1:0]          src_col_out,
   output logic [PIX_W-1:0]       pix_out
);

   localparam int HALF_I = SIDE / 2;
   localparam int LAST_I = SIDE - 1;
   localparam int PAIR_I = 2 * (SIDE / 2);
   localparam logic [CW-1:0] HALF = CW'(HALF_I);
   localparam logic [CW-1:0] LAST = CW'(LAST_I);
   localparam logic [CW-1:0] ZERO = '0;

   fgr_ctl_type      ctl_ff, ctl_in;
   logic [CW-1:0]    src_row_ff, src_row_in;
   logic [CW-1:0]    src_col_ff, src_col_in;
   logic [PIX_W-1:0] pix_ff;

   logic          in_range;
   logic [CW-1:0] r, c, rr, cc;
   logic          lo, rt;
   logic [1:0]    quad;
   logic [1:0]    qsrc;
   logic [8:0]    row_end, col_end;
   logic          outside;

   always_comb begin
      in_range = (32'(row) < 32'(SIDE)) && (32'(col) < 32'(SIDE));
      r  = CW'(row);
      c  = CW'(col);
      rr = LAST - r;
      cc = LAST - c;
      lo = (r >= HALF);
      rt = (c >= HALF);
      quad = {lo, rt};
      qsrc = cfg.quadrant_sources[{quad, 1'b0} +: 2];
      row_end = {1'b0, cfg.crop_top} + {1'b0, cfg.crop_height};
      col_end = {1'b0, cfg.crop_left} + {1'b0, cfg.crop_width};
      outside = (row < cfg.crop_top) || ({1'b0, row} > row_end) ||
                (col < cfg.crop_left) || ({1'b0, col} > col_end);

      src_row_in = r;
      src_col_in = c;
      unique case (cfg.transform_mode)
         MODE_FLIP_H:   src_col_in = cc;
         MODE_FLIP_V:   src_row_in = rr;
         MODE_ROT90: begin
            src_row_in = cc;
            src_col_in = r;
         end
         MODE_ROT180: begin
            src_row_in = rr;
            src_col_in = cc;
         end
         MODE_ROT270: begin
            src_row_in = c;
            src_col_in = rr;
         end
         MODE_MIRROR_L: src_col_in = (c > cc) ? cc : c;
         MODE_MIRROR_R: src_col_in = (c < cc) ? cc : c;
         MODE_MIRROR_U: src_row_in = (r > rr) ? rr : r;
         MODE_MIRROR_D: src_row_in = (r < rr) ? rr : r;
         MODE_ZOOM: begin
            src_row_in = (r >> 1) + (cfg.zoom_quarter[1] ? HALF : ZERO);
            src_col_in = (c >> 1) + (cfg.zoom_quarter[0] ? HALF : ZERO);
         end
         MODE_SHUFFLE: begin
            // odd side: last row/column beyond both halves passes through
            if ((32'(r) < 32'(PAIR_I)) && (32'(c) < 32'(PAIR_I))) begin
               src_row_in = r - (lo ? HALF : ZERO) + (qsrc[1] ? HALF : ZERO);
               src_col_in = c - (rt ? HALF : ZERO) + (qsrc[0] ? HALF : ZERO);
            end
         end
         default: begin
            src_row_in = r;
            src_col_in = c;
         end
      endcase

      // stores always go to the addressed pixel
      if (!kind) begin
         src_row_in = r;
         src_col_in = c;
      end

      ctl_in.rd    = accept && kind;
      ctl_in.wr    = accept && !kind && in_range;
      ctl_in.zero  = !in_range;
      ctl_in.white = in_range && outside && (cfg.transform_mode == MODE_CROP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      src_row_ff <= src_row_in;
      src_col_ff <= src_col_in;
      pix_ff     <= pix;
   end

   assign ctl_out     = ctl_ff;
   assign src_row_out = src_row_ff;
   assign src_col_out = src_col_ff;
   assign pix_out     = pix_ff;

endmodule

`default_nettype wire

>>> sv/fgr_frame_mem.sv
`default_nettype none

module fgr_frame_mem import fgr_pkg::*; #(
   parameter int SIDE = SIDE_DEFAULT,
   localparam int CW = $clog2(SIDE)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fgr_ctl_type       ctl,
   input  wire logic [CW-1:0]     src_row,
   input  wire logic [CW-1:0]     src_col,
   input  wire logic [PIX_W-1:0]  wdata,
   output fgr_ctl_type            rsp_ctl,
   output logic [PIX_W-1:0]       rdata
);

   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);

   logic [PIX_W-1:0] frame_mem [DEPTH];

   fgr_ctl_type      rsp_ctl_ff;
   logic [PIX_W-1:0] rdata_ff;
   logic [AW-1:0]    addr;

   // row-major: row * SIDE + col
   assign addr = AW'(src_row) * AW'(SIDE) + AW'(src_col);

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         frame_mem[addr] <= wdata;
      end
      rdata_ff <= frame_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ctl_ff <= '0;
      end else begin
         rsp_ctl_ff <= ctl;
      end
   end

   assign rsp_ctl = rsp_ctl_ff;
   assign rdata   = rdata_ff;

endmodule

`default_nettype wire

>>> sv/frame_geometry_remap_core.sv
// Frame remap core: one pixel store or transformed read per clock.
// A read's result strobes on rsp_valid once the start transfer has passed the
// coordinate remap register and then the frame memory read register.
// Throughput one item per cycle, set by the single frame memory port; busy stays low.
// Synchronous reset restores register defaults; frame contents are not cleared.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
`default_nettype none

module frame_geometry_remap_core import fgr_pkg::*; #(
   parameter int SIDE = SIDE_DEFAULT,
   localparam int CW = $clog2(SIDE)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_kind,
   input  wire logic [7:0]           req_row,
   input  wire logic [7:0]           req_col,
   input  wire logic [CHAN_W-1:0]    req_red_in,
   input  wire logic [CHAN_W-1:0]    req_green_in,
   input  wire logic [CHAN_W-1:0]    req_blue_in,
   output logic                      rsp_valid,
   output logic [CHAN_W-1:0]         rsp_red_out,
   output logic [CHAN_W-1:0]         rsp_green_out,
   output logic [CHAN_W-1:0]         rsp_blue_out,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   fgr_cfg_type      cfg_ff, cfg_in;
   fgr_ctl_type      stage_ctl, rsp_ctl;
   logic [CW-1:0]    src_row, src_col;
   logic [PIX_W-1:0] stage_pix, rdata;
   logic             accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TRANSFORM_MODE:   cfg_in.transform_mode   = csr_wdata[3:0];
            REG_ZOOM_QUARTER:     cfg_in.zoom_quarter     = csr_wdata[1:0];
            REG_QUADRANT_SOURCES: cfg_in.quadrant_sources = csr_wdata;
            REG_CROP_LEFT:        cfg_in.crop_left        = csr_wdata;
            REG_CROP_TOP:         cfg_in.crop_top         = csr_wdata;
            REG_CROP_HEIGHT:      cfg_in.crop_height      = csr_wdata;
            REG_CROP_WIDTH:       cfg_in.crop_width       = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transform_mode   <= MODE_RESET;
         cfg_ff.zoom_quarter     <= ZOOM_RESET;
         cfg_ff.quadrant_sources <= QSRC_RESET;
         cfg_ff.crop_left        <= CROP_ORIGIN_RESET;
         cfg_ff.crop_top         <= CROP_ORIGIN_RESET;
         cfg_ff.crop_height      <= CROP_SPAN_RESET;
         cfg_ff.crop_width       <= CROP_SPAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fgr_remap #(.SIDE(SIDE)) u_remap (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_kind),
      .row         (req_row),
      .col         (req_col),
      .pix         ({req_red_in, req_green_in, req_blue_in}),
      .cfg         (cfg_ff),
      .ctl_out     (stage_ctl),
      .src_row_out (src_row),
      .src_col_out (src_col),
      .pix_out     (stage_pix)
   );

   fgr_frame_mem #(.SIDE(SIDE)) u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stage_ctl),
      .src_row (src_row),
      .src_col (src_col),
      .wdata   (stage_pix),
      .rsp_ctl (rsp_ctl),
      .rdata   (rdata)
   );

   assign rsp_valid = rsp_ctl.rd;

   always_comb begin
      if (rsp_ctl.zero) begin
         rsp_red_out   = '0;
         rsp_green_out = '0;
         rsp_blue_out  = '0;
      end else if (rsp_ctl.white) begin
         rsp_red_out   = CHAN_WHITE;
         rsp_green_out = CHAN_WHITE;
         rsp_blue_out  = CHAN_WHITE;
      end else begin
         rsp_red_out   = rdata[23:16];
         rsp_green_out = rdata[15:8];
         rsp_blue_out  = rdata[7:0];
      end
   end

endmodule

`default_nettype wire

>>> verif/tb_frame_geometry_remap_core.sv
`timescale 1ns / 1ps

module tb_frame_geometry_remap_core;
   import fgr_pkg::*;

   localparam bit KIND_STORE = 1'b0;
   localparam bit KIND_READ  = 1'b1;
   localparam int QUIET_LIMIT = 10000;
   localparam int PHASES = 64;
   localparam int ITEMS_PER_PHASE = 23;
   localparam bit [23:0] WHITE_PX = {3{CHAN_WHITE}};

   typedef enum bit [1:0] {D_STORE, D_READ, D_CSR} dir_op_type;

   // for D_CSR rows: row holds the register index, col the write data
   typedef struct packed {
      dir_op_type op;
      bit [7:0]   row;
      bit [7:0]   col;
      bit [23:0]  px;
      bit         chk;
      bit [23:0]  want;
   } dir_row_type;

   localparam dir_row_type DIR_TBL [0:22] = '{
      '{D_STORE, 8'd0,   8'd0,   24'h000000, 1'b0, 24'h000000},
      '{D_STORE, 8'd0,   8'd255, 24'hFFFFFF, 1'b0, 24'h000000},
      '{D_STORE, 8'd255, 8'd0,   24'hA55AC3, 1'b0, 24'h000000},
      '{D_STORE, 8'd255, 8'd255, 24'h5AA53C, 1'b0, 24'h000000},
      '{D_STORE, 8'd128, 8'd127, 24'h123456, 1'b0, 24'h000000},
      '{D_READ,  8'd0,   8'd0,   24'hFFFFFF, 1'b1, 24'h000000},
      '{D_READ,  8'd0,   8'd255, 24'h000000, 1'b1, 24'hFFFFFF},
      '{D_READ,  8'd255, 8'd0,   24'h000000, 1'b1, 24'hA55AC3},
      '{D_READ,  8'd255, 8'd255, 24'h000000, 1'b1, 24'h5AA53C},
      '{D_READ,  8'd128, 8'd127, 24'h000000, 1'b1, 24'h123456},
      '{D_CSR,   8'(REG_TRANSFORM_MODE), 8'(MODE_FLIP_H), 24'h0, 1'b0, 24'h0},
      '{D_READ,  8'd0,   8'd0,   24'h000000, 1'b0, 24'h000000},
      '{D_READ,  8'd128, 8'd128, 24'h000000, 1'b0, 24'h000000},
      '{D_CSR,   8'(REG_TRANSFORM_MODE), 8'(MODE_CROP), 24'h0, 1'b0, 24'h0},
      '{D_CSR,   8'(REG_CROP_LEFT),  8'd1, 24'h0, 1'b0, 24'h0},
      '{D_CSR,   8'(REG_CROP_WIDTH), 8'd0, 24'h0, 1'b0, 24'h0},
      '{D_READ,  8'd0,   8'd0,   24'h000000, 1'b1, WHITE_PX},
      '{D_READ,  8'd255, 8'd255, 24'h000000, 1'b1, WHITE_PX},
      '{D_CSR,   8'(REG_CROP_LEFT),  8'd0, 24'h0, 1'b0, 24'h0},
      '{D_READ,  8'd255, 8'd0,   24'h000000, 1'b0, 24'h000000},
      '{D_STORE, 8'd255, 8'd0,   24'hFF0000, 1'b0, 24'h000000},
      '{D_READ,  8'd255, 8'd0,   24'h000000, 1'b0, 24'h000000},
      '{D_CSR,   8'(REG_TRANSFORM_MODE), 8'(MODE_RESET), 24'h0, 1'b0, 24'h0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_kind = 1'b0;
   logic [7:0]           req_row = '0;
   logic [7:0]           req_col = '0;
   logic [CHAN_W-1:0]    req_red_in = '0;
   logic [CHAN_W-1:0]    req_green_in = '0;
   logic [CHAN_W-1:0]    req_blue_in = '0;
   logic                 rsp_valid;
   logic [CHAN_W-1:0]    rsp_red_out;
   logic [CHAN_W-1:0]    rsp_green_out;
   logic [CHAN_W-1:0]    rsp_blue_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // shadow copy of the frame and of the register file
   bit [23:0]   frame_img [65536];
   bit          img_written [65536];
   bit [15:0]   written_at [$];
   bit [15:0]   last_store_at;
   fgr_cfg_type cfg;

   bit [23:0]   pixel_due [$];
   bit [23:0]   want_px;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int unsigned send_gap_pct = 0;
   int unsigned gap_pct [4] = '{0, 45, 0, 15};

   frame_geometry_remap_core u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // source pixel of output position (r, c) under the current transform
   function automatic void remap_src(input bit [7:0] r, input bit [7:0] c,
                                     output bit white, output bit [7:0] sr,
                                     output bit [7:0] sc);
      bit [7:0] rr;
      bit [7:0] cc;
      bit [1:0] src;
      rr = 8'd255 - r;
      cc = 8'd255 - c;
      white = 1'b0;
      sr = r;
      sc = c;
      case (cfg.transform_mode)
         MODE_FLIP_H: sc = cc;
         MODE_FLIP_V: sr = rr;
         MODE_ROT90: begin
            sr = cc;
            sc = r;
         end
         MODE_ROT180: begin
            sr = rr;
            sc = cc;
         end
         MODE_ROT270: begin
            sr = c;
            sc = rr;
         end
         MODE_MIRROR_L: if (c > cc) sc = cc;
         MODE_MIRROR_R: if (c < cc) sc = cc;
         MODE_MIRROR_U: if (r > rr) sr = rr;
         MODE_MIRROR_D: if (r < rr) sr = rr;
         MODE_ZOOM: begin
            sr = {cfg.zoom_quarter[1], r[7:1]};
            sc = {cfg.zoom_quarter[0], c[7:1]};
         end
         MODE_SHUFFLE: begin
            src = cfg.quadrant_sources[2 * {r[7], c[7]} +: 2];
            sr = {src[1], r[6:0]};
            sc = {src[0], c[6:0]};
         end
         MODE_CROP: begin
            // window bounds can run past 255, compare in full width
            white = int'(r) < int'(cfg.crop_top) ||
                    int'(r) > int'(cfg.crop_top) + int'(cfg.crop_height) ||
                    int'(c) < int'(cfg.crop_left) ||
                    int'(c) > int'(cfg.crop_left) + int'(cfg.crop_width);
         end
         default: ;
      endcase
   endfunction

   // find an output position whose source pixel has been stored
   function automatic bit choose_read(output bit [7:0] r, output bit [7:0] c);
      int        k;
      int        tr;
      int        tc;
      int        q;
      bit [1:0]  src;
      bit [15:0] pos;
      bit        wt;
      bit [7:0]  sr;
      bit [7:0]  sc;
      r = '0;
      c = '0;
      if (written_at.size() == 0) return 1'b0;
      for (k = 0; k < 64; k++) begin
         if ($urandom_range(99) < 30 && img_written[last_store_at])
            pos = last_store_at;
         else
            pos = written_at[$urandom_range(written_at.size() - 1)];
         case (cfg.transform_mode)
            MODE_ZOOM: begin
               tr = 2 * (int'(pos[15:8]) - (cfg.zoom_quarter[1] ? 128 : 0)) +
                    int'($urandom_range(1));
               tc = 2 * (int'(pos[7:0]) - (cfg.zoom_quarter[0] ? 128 : 0)) +
                    int'($urandom_range(1));
            end
            MODE_SHUFFLE: begin
               q = $urandom_range(3);
               src = cfg.quadrant_sources[2 * q +: 2];
               tr = int'(pos[15:8]) - (src[1] ? 128 : 0) + (q / 2) * 128;
               tc = int'(pos[7:0]) - (src[0] ? 128 : 0) + (q % 2) * 128;
            end
            MODE_CROP: begin
               if ($urandom_range(1)) begin
                  tr = $urandom_range(255);
                  tc = $urandom_range(255);
               end else begin
                  tr = int'(pos[15:8]);
                  tc = int'(pos[7:0]);
               end
            end
            default: begin
               // any image of the pixel under the square's symmetries
               if ($urandom_range(1)) begin
                  tr = int'(pos[7:0]);
                  tc = int'(pos[15:8]);
               end else begin
                  tr = int'(pos[15:8]);
                  tc = int'(pos[7:0]);
               end
               if ($urandom_range(1)) tr = 255 - tr;
               if ($urandom_range(1)) tc = 255 - tc;
            end
         endcase
         if (tr >= 0 && tr <= 255 && tc >= 0 && tc <= 255) begin
            r = tr[7:0];
            c = tc[7:0];
            remap_src(r, c, wt, sr, sc);
            if (wt || img_written[{sr, sc}]) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic send_item(input bit kind, input bit [7:0] r, input bit [7:0] c,
                            input bit [23:0] px, input bit chk, input bit [23:0] want);
      bit       wt;
      bit [7:0] sr;
      bit [7:0] sc;
      while ($urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_kind     <= kind;
      req_row      <= r;
      req_col      <= c;
      req_red_in   <= px[23:16];
      req_green_in <= px[15:8];
      req_blue_in  <= px[7:0];
      do @(posedge clock); while (busy);
      if (kind == KIND_STORE) begin
         frame_img[{r, c}] = px;
         if (!img_written[{r, c}]) begin
            img_written[{r, c}] = 1'b1;
            written_at.push_back({r, c});
         end
         last_store_at = {r, c};
      end else if (chk) begin
         pixel_due.push_back(want);
      end else begin
         remap_src(r, c, wt, sr, sc);
         pixel_due.push_back(wt ? WHITE_PX : frame_img[{sr, sc}]);
      end
   endtask

   // caller lowers csr_valid after the last write of a burst
   task automatic csr_write(input fgr_reg_type sel, input bit [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         REG_TRANSFORM_MODE:   cfg.transform_mode = val[3:0];
         REG_ZOOM_QUARTER:     cfg.zoom_quarter = val[1:0];
         REG_QUADRANT_SOURCES: cfg.quadrant_sources = val;
         REG_CROP_LEFT:        cfg.crop_left = val;
         REG_CROP_TOP:         cfg.crop_top = val;
         REG_CROP_HEIGHT:      cfg.crop_height = val;
         REG_CROP_WIDTH:       cfg.crop_width = val;
         default: ;
      endcase
   endtask

   // stores give no result, so wait out the pipe once reads are all back
   task automatic wait_frame_quiet();
      start <= 1'b0;
      while (pixel_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pixel_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result %h/%h/%h with nothing expected", $realtime,
                        rsp_red_out, rsp_green_out, rsp_blue_out);
         end else begin
            want_px = pixel_due.pop_front();
            if (rsp_red_out !== want_px[23:16] || rsp_green_out !== want_px[15:8] ||
                rsp_blue_out !== want_px[7:0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: pixel mismatch, expected %h/%h/%h got %h/%h/%h",
                           $realtime, want_px[23:16], want_px[15:8], want_px[7:0],
                           rsp_red_out, rsp_green_out, rsp_blue_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int          i;
      int          p;
      int          n;
      int          sel;
      dir_row_type d;
      bit [7:0]    rd_row;
      bit [7:0]    rd_col;
      bit [7:0]    qsrc;
      bit [7:0]    win [4];
      cfg.transform_mode   = MODE_RESET;
      cfg.zoom_quarter     = ZOOM_RESET;
      cfg.quadrant_sources = QSRC_RESET;
      cfg.crop_left        = CROP_ORIGIN_RESET;
      cfg.crop_top         = CROP_ORIGIN_RESET;
      cfg.crop_height      = CROP_SPAN_RESET;
      cfg.crop_width       = CROP_SPAN_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 23; i++) begin
         d = DIR_TBL[i];
         case (d.op)
            D_STORE: send_item(KIND_STORE, d.row, d.col, d.px, 1'b0, 24'h0);
            D_READ:  send_item(KIND_READ, d.row, d.col, d.px, d.chk, d.want);
            default: begin
               wait_frame_quiet();
               csr_write(fgr_reg_type'(d.row[2:0]), d.col);
               csr_valid <= 1'b0;
            end
         endcase
      end

      for (p = 0; p < PHASES; p++) begin
         sel = p / 16;
         case (sel)
            0: begin
               qsrc = QSRC_RESET;
               win = '{CROP_ORIGIN_RESET, CROP_ORIGIN_RESET, CROP_SPAN_RESET,
                       CROP_SPAN_RESET};
            end
            1: begin
               qsrc = 8'h00;
               win = '{8'd255, 8'd255, 8'd255, 8'd255};
            end
            2: begin
               qsrc = 8'hFF;
               win = '{8'd0, 8'd0, 8'd0, 8'd0};
            end
            default: begin
               qsrc = 8'($urandom);
               win = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
            end
         endcase
         wait_frame_quiet();
         csr_write(REG_TRANSFORM_MODE, 8'(p % 16));
         csr_write(REG_ZOOM_QUARTER, 8'(sel));
         csr_write(REG_QUADRANT_SOURCES, qsrc);
         csr_write(REG_CROP_LEFT, win[0]);
         csr_write(REG_CROP_TOP, win[1]);
         csr_write(REG_CROP_HEIGHT, win[2]);
         csr_write(REG_CROP_WIDTH, win[3]);
         csr_valid <= 1'b0;
         send_gap_pct = gap_pct[p % 4];
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) < 35 || !choose_read(rd_row, rd_col))
               send_item(KIND_STORE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         24'($urandom), 1'b0, 24'h0);
            else
               send_item(KIND_READ, rd_row, rd_col, 24'($urandom), 1'b0, 24'h0);
         end
      end

      send_gap_pct = 0;
      wait_frame_quiet();
      if (mismatch_count == 0 && pixel_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
sv/fgr_pkg.sv
sv/fgr_remap.sv
sv/fgr_frame_mem.sv
sv/frame_geometry_remap_core.sv
verif/tb_frame_geometry_remap_core.sv
